### rtl/core/cpid_pkg.sv
package cpid_pkg;

  // Default binary point position of all fixed-point values.
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Field widths.
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned YAW_W     = 19;
  localparam int unsigned SCALE_W   = 31;
  localparam int unsigned WIDE_W    = 64;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NUM_AXES  = 4;
  localparam int unsigned NUM_VEL   = 3;

  // Stream word widths, padded to whole bytes.
  localparam int unsigned S_TDATA_W = 216;
  localparam int unsigned M_TDATA_W = 224;

  // Saturation bounds of the signed 32-bit range.
  localparam logic signed [WIDE_W-1:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [WIDE_W-1:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POSITION_MODE = 3'd0,
    REG_TARGET_X      = 3'd1,
    REG_TARGET_Y      = 3'd2,
    REG_TARGET_Z      = 3'd3,
    REG_YAW_TARGET    = 3'd4,
    REG_DERIV_SCALE   = 3'd5
  } cfg_reg_e;

  // Controller axes; yaw runs through the same PID sequence.
  typedef enum logic [1:0] {
    AX_X   = 2'd0,
    AX_Y   = 2'd1,
    AX_Z   = 2'd2,
    AX_YAW = 2'd3
  } axis_e;

  // Operations of the shared arithmetic unit.
  typedef enum logic [1:0] {
    ALU_SUB = 2'd0,
    ALU_MUL = 2'd1,
    ALU_RND = 2'd2,
    ALU_NUM = 2'd3
  } alu_op_e;

  // Sequencer steps.
  typedef enum logic [3:0] {
    ST_IDLE  = 4'd0,
    ST_PERR  = 4'd1,
    ST_PMUL  = 4'd2,
    ST_PRND  = 4'd3,
    ST_VERR  = 4'd4,
    ST_NUM   = 4'd5,
    ST_DMUL  = 4'd6,
    ST_DRND  = 4'd7,
    ST_IMUL  = 4'd8,
    ST_IRND  = 4'd9,
    ST_KPMUL = 4'd10,
    ST_KPRND = 4'd11,
    ST_KDMUL = 4'd12,
    ST_KDRND = 4'd13,
    ST_DONE  = 4'd14
  } seq_state_e;

  // One request to the shared arithmetic unit.
  typedef struct packed {
    alu_op_e                   op;
    logic signed [DATA_W-1:0]  a;
    logic signed [DATA_W-1:0]  b;
    logic signed [WIDE_W-1:0]  c;
  } alu_req_t;

  // Configuration register file.
  typedef struct packed {
    logic                      position_mode;
    logic signed [DATA_W-1:0]  target_x;
    logic signed [DATA_W-1:0]  target_y;
    logic signed [DATA_W-1:0]  target_z;
    logic signed [YAW_W-1:0]   yaw_target;
    logic [SCALE_W-1:0]        deriv_scale;
  } cpid_cfg_t;

  // One odometry sample.
  typedef struct packed {
    logic signed [DATA_W-1:0]  pos_x;
    logic signed [DATA_W-1:0]  pos_y;
    logic signed [DATA_W-1:0]  pos_z;
    logic signed [DATA_W-1:0]  vel_x;
    logic signed [DATA_W-1:0]  vel_y;
    logic signed [DATA_W-1:0]  vel_z;
    logic signed [YAW_W-1:0]   yaw_meas;
  } cpid_sample_t;

  // One controller result.
  typedef struct packed {
    logic signed [DATA_W-1:0]  thrust_x;
    logic signed [DATA_W-1:0]  thrust_y;
    logic signed [DATA_W-1:0]  thrust_z;
    logic signed [DATA_W-1:0]  yaw_drive;
    logic signed [DATA_W-1:0]  verr_x;
    logic signed [DATA_W-1:0]  verr_y;
    logic signed [DATA_W-1:0]  verr_z;
  } cpid_result_t;

endpackage

### rtl/core/cpid_alu.sv
module cpid_alu #(
  parameter int unsigned FRAC_BITS = cpid_pkg::FRAC_BITS_DEF
) (
  input  logic                                    clk_i,
  input  cpid_pkg::alu_req_t                      req_i,
  output logic signed [cpid_pkg::WIDE_W-1:0]      raw_o,
  output logic signed [cpid_pkg::DATA_W-1:0]      sat_o
);

  localparam logic signed [cpid_pkg::WIDE_W-1:0] Half =
    64'sd1 <<< (FRAC_BITS - 1);

  logic signed [cpid_pkg::DATA_W-1:0] mul_a;
  logic signed [cpid_pkg::DATA_W-1:0] mul_b;
  logic signed [cpid_pkg::WIDE_W-1:0] prod_q;
  logic signed [cpid_pkg::WIDE_W-1:0] prod_d;
  logic signed [cpid_pkg::WIDE_W-1:0] rnd;
  logic signed [cpid_pkg::WIDE_W-1:0] a_ext;
  logic signed [cpid_pkg::WIDE_W-1:0] b_ext;
  logic signed [cpid_pkg::WIDE_W-1:0] c_low_ext;
  logic signed [cpid_pkg::WIDE_W-1:0] sum;

  // The product is registered, and the rounding step reads the registered product.
  assign mul_a  = req_i.a;
  assign mul_b  = req_i.b;
  assign prod_d = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    if (req_i.op == cpid_pkg::ALU_MUL) begin
      prod_q <= prod_d;
    end
  end

  // Round half up, then drop the fraction bits.
  assign rnd = (prod_q + Half) >>> FRAC_BITS;

  assign a_ext     = {{(cpid_pkg::WIDE_W-cpid_pkg::DATA_W){req_i.a[cpid_pkg::DATA_W-1]}},
                      req_i.a};
  assign b_ext     = {{(cpid_pkg::WIDE_W-cpid_pkg::DATA_W){req_i.b[cpid_pkg::DATA_W-1]}},
                      req_i.b};
  assign c_low_ext = {{(cpid_pkg::WIDE_W-cpid_pkg::DATA_W){req_i.c[cpid_pkg::DATA_W-1]}},
                      req_i.c[cpid_pkg::DATA_W-1:0]};

  // One wide adder serves the subtract, numerator and rounding operations.
  always_comb begin
    unique case (req_i.op)
      cpid_pkg::ALU_SUB: sum = a_ext - b_ext;
      cpid_pkg::ALU_NUM: sum = a_ext - (b_ext <<< 2) + (c_low_ext <<< 1) + c_low_ext;
      cpid_pkg::ALU_RND: sum = rnd + req_i.c;
      cpid_pkg::ALU_MUL: sum = '0;
      default:           sum = '0;
    endcase
  end

  // Clamp to the signed 32-bit range.
  always_comb begin
    if (sum > cpid_pkg::SAT_MAX) begin
      sat_o = cpid_pkg::SAT_MAX[cpid_pkg::DATA_W-1:0];
    end else if (sum < cpid_pkg::SAT_MIN) begin
      sat_o = cpid_pkg::SAT_MIN[cpid_pkg::DATA_W-1:0];
    end else begin
      sat_o = sum[cpid_pkg::DATA_W-1:0];
    end
  end

  assign raw_o = sum;

endmodule

### rtl/core/cpid_seq.sv
module cpid_seq #(
  parameter int unsigned FRAC_BITS = cpid_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  cpid_pkg::cpid_sample_t sample_i,
  input  cpid_pkg::cpid_cfg_t    cfg_i,
  input  logic                   res_free_i,
  output logic                   idle_o,
  output logic                   done_o,
  output cpid_pkg::cpid_result_t result_o
);

  localparam int unsigned DW = cpid_pkg::DATA_W;
  localparam int unsigned WW = cpid_pkg::WIDE_W;

  // Gains, rounded to the binary point.
  localparam logic signed [WW-1:0] One    = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [DW-1:0] KPos   = DW'((One + 2) / 5);
  localparam logic signed [DW-1:0] KXyP   = DW'(One * 4);
  localparam logic signed [DW-1:0] KXyD   = DW'(One * 2);
  localparam logic signed [DW-1:0] KXyI   = DW'((One + 12) / 25);
  localparam logic signed [DW-1:0] KZP    = DW'(One * 10);
  localparam logic signed [DW-1:0] KZD    = DW'((One / 2) * 7);
  localparam logic signed [DW-1:0] KZI    = DW'((One + 12) / 25);
  localparam logic signed [DW-1:0] KYawP  = DW'((One * 3 + 5) / 10);
  localparam logic signed [DW-1:0] KYawD  = DW'(One / 2);
  localparam logic signed [DW-1:0] KYawI  = '0;
  localparam logic signed [WW-1:0] Hover  = One * 15;

  cpid_pkg::seq_state_e state_q, state_d;
  cpid_pkg::axis_e      ax_q, ax_d;

  cpid_pkg::cpid_sample_t smp_q;
  logic signed [DW-1:0]   e_q;
  logic signed [DW-1:0]   n_q;
  logic signed [WW-1:0]   acc_q;

  // Controller memory: error history and integrators per axis.
  logic signed [DW-1:0] last_q  [cpid_pkg::NUM_AXES];
  logic signed [DW-1:0] prev_q  [cpid_pkg::NUM_AXES];
  logic signed [DW-1:0] integ_q [cpid_pkg::NUM_AXES];
  logic signed [DW-1:0] thr_q   [cpid_pkg::NUM_AXES];
  logic signed [DW-1:0] verr_q  [cpid_pkg::NUM_VEL];

  logic signed [DW-1:0] tgt_sel, pos_sel, vel_sel;
  logic signed [DW-1:0] kp_sel, kd_sel, ki_sel;
  logic signed [WW-1:0] hover_sel;
  logic signed [WW-1:0] integ_ext;

  cpid_pkg::alu_req_t   alu_req;
  logic signed [WW-1:0] alu_raw;
  logic signed [DW-1:0] alu_sat;

  cpid_alu #(
    .FRAC_BITS (FRAC_BITS)
  ) u_alu (
    .clk_i (clk_i),
    .req_i (alu_req),
    .raw_o (alu_raw),
    .sat_o (alu_sat)
  );

  // Per-axis operands and gains.
  always_comb begin
    hover_sel = '0;
    case (ax_q)
      cpid_pkg::AX_X: begin
        tgt_sel = cfg_i.target_x;
        pos_sel = smp_q.pos_x;
        vel_sel = smp_q.vel_x;
        kp_sel  = KXyP;
        kd_sel  = KXyD;
        ki_sel  = KXyI;
      end
      cpid_pkg::AX_Y: begin
        tgt_sel = cfg_i.target_y;
        pos_sel = smp_q.pos_y;
        vel_sel = smp_q.vel_y;
        kp_sel  = KXyP;
        kd_sel  = KXyD;
        ki_sel  = KXyI;
      end
      cpid_pkg::AX_Z: begin
        tgt_sel   = cfg_i.target_z;
        pos_sel   = smp_q.pos_z;
        vel_sel   = smp_q.vel_z;
        kp_sel    = KZP;
        kd_sel    = KZD;
        ki_sel    = KZI;
        hover_sel = Hover;
      end
      default: begin
        tgt_sel = {{(DW-cpid_pkg::YAW_W){cfg_i.yaw_target[cpid_pkg::YAW_W-1]}},
                   cfg_i.yaw_target};
        pos_sel = {{(DW-cpid_pkg::YAW_W){smp_q.yaw_meas[cpid_pkg::YAW_W-1]}},
                   smp_q.yaw_meas};
        vel_sel = '0;
        kp_sel  = KYawP;
        kd_sel  = KYawD;
        ki_sel  = KYawI;
      end
    endcase
  end

  assign integ_ext = {{(WW-DW){integ_q[ax_q][DW-1]}}, integ_q[ax_q]};

  // Next step and the request to the shared unit.
  always_comb begin
    state_d       = state_q;
    ax_d          = ax_q;
    done_o        = 1'b0;
    alu_req.op    = cpid_pkg::ALU_SUB;
    alu_req.a     = '0;
    alu_req.b     = '0;
    alu_req.c     = '0;
    unique case (state_q)
      cpid_pkg::ST_IDLE: begin
        if (start_i) begin
          ax_d    = cpid_pkg::AX_X;
          state_d = cpid_pkg::ST_PERR;
        end
      end
      cpid_pkg::ST_PERR: begin
        // Position error, the plain setpoint, or the yaw error.
        alu_req.a = tgt_sel;
        if (cfg_i.position_mode || ax_q == cpid_pkg::AX_YAW) begin
          alu_req.b = pos_sel;
        end
        if (ax_q == cpid_pkg::AX_YAW) begin
          state_d = cpid_pkg::ST_NUM;
        end else if (cfg_i.position_mode) begin
          state_d = cpid_pkg::ST_PMUL;
        end else begin
          state_d = cpid_pkg::ST_VERR;
        end
      end
      cpid_pkg::ST_PMUL: begin
        alu_req.op = cpid_pkg::ALU_MUL;
        alu_req.a  = KPos;
        alu_req.b  = e_q;
        state_d    = cpid_pkg::ST_PRND;
      end
      cpid_pkg::ST_PRND: begin
        alu_req.op = cpid_pkg::ALU_RND;
        state_d    = cpid_pkg::ST_VERR;
      end
      cpid_pkg::ST_VERR: begin
        alu_req.a = e_q;
        alu_req.b = vel_sel;
        state_d   = cpid_pkg::ST_NUM;
      end
      cpid_pkg::ST_NUM: begin
        // Three-point backward difference numerator.
        alu_req.op = cpid_pkg::ALU_NUM;
        alu_req.a  = prev_q[ax_q];
        alu_req.b  = last_q[ax_q];
        alu_req.c  = {{(WW-DW){e_q[DW-1]}}, e_q};
        state_d    = cpid_pkg::ST_DMUL;
      end
      cpid_pkg::ST_DMUL: begin
        alu_req.op = cpid_pkg::ALU_MUL;
        alu_req.a  = n_q;
        alu_req.b  = {1'b0, cfg_i.deriv_scale};
        state_d    = cpid_pkg::ST_DRND;
      end
      cpid_pkg::ST_DRND: begin
        alu_req.op = cpid_pkg::ALU_RND;
        state_d    = cpid_pkg::ST_IMUL;
      end
      cpid_pkg::ST_IMUL: begin
        alu_req.op = cpid_pkg::ALU_MUL;
        alu_req.a  = ki_sel;
        alu_req.b  = e_q;
        state_d    = cpid_pkg::ST_IRND;
      end
      cpid_pkg::ST_IRND: begin
        alu_req.op = cpid_pkg::ALU_RND;
        alu_req.c  = integ_ext;
        state_d    = cpid_pkg::ST_KPMUL;
      end
      cpid_pkg::ST_KPMUL: begin
        alu_req.op = cpid_pkg::ALU_MUL;
        alu_req.a  = kp_sel;
        alu_req.b  = e_q;
        state_d    = cpid_pkg::ST_KPRND;
      end
      cpid_pkg::ST_KPRND: begin
        // The integrator already holds this sample's update here.
        alu_req.op = cpid_pkg::ALU_RND;
        alu_req.c  = integ_ext + hover_sel;
        state_d    = cpid_pkg::ST_KDMUL;
      end
      cpid_pkg::ST_KDMUL: begin
        alu_req.op = cpid_pkg::ALU_MUL;
        alu_req.a  = kd_sel;
        alu_req.b  = n_q;
        state_d    = cpid_pkg::ST_KDRND;
      end
      cpid_pkg::ST_KDRND: begin
        alu_req.op = cpid_pkg::ALU_RND;
        alu_req.c  = acc_q;
        if (ax_q == cpid_pkg::AX_YAW) begin
          state_d = cpid_pkg::ST_DONE;
        end else begin
          ax_d    = cpid_pkg::axis_e'(ax_q + 2'd1);
          state_d = cpid_pkg::ST_PERR;
        end
      end
      cpid_pkg::ST_DONE: begin
        if (res_free_i) begin
          done_o  = 1'b1;
          state_d = cpid_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cpid_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cpid_pkg::ST_IDLE;
      ax_q    <= cpid_pkg::AX_X;
    end else begin
      state_q <= state_d;
      ax_q    <= ax_d;
    end
  end

  // Error history and integrators advance once per axis.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < cpid_pkg::NUM_AXES; i++) begin
        last_q[i]  <= '0;
        prev_q[i]  <= '0;
        integ_q[i] <= '0;
      end
    end else begin
      case (state_q)
        cpid_pkg::ST_IRND: begin
          integ_q[ax_q] <= alu_sat;
        end
        cpid_pkg::ST_KDRND: begin
          prev_q[ax_q] <= last_q[ax_q];
          last_q[ax_q] <= e_q;
        end
        default: begin
        end
      endcase
    end
  end

  // Working registers and per-axis results.
  always_ff @(posedge clk_i) begin
    if (start_i && state_q == cpid_pkg::ST_IDLE) begin
      smp_q <= sample_i;
    end
    case (state_q) inside
      cpid_pkg::ST_PERR, cpid_pkg::ST_PRND: begin
        e_q <= alu_sat;
      end
      cpid_pkg::ST_VERR: begin
        e_q          <= alu_sat;
        verr_q[ax_q] <= alu_sat;
      end
      cpid_pkg::ST_NUM, cpid_pkg::ST_DRND: begin
        n_q <= alu_sat;
      end
      cpid_pkg::ST_KPRND: begin
        acc_q <= alu_raw;
      end
      cpid_pkg::ST_KDRND: begin
        thr_q[ax_q] <= alu_sat;
      end
      default: begin
      end
    endcase
  end

  assign idle_o = (state_q == cpid_pkg::ST_IDLE);

  assign result_o.thrust_x  = thr_q[cpid_pkg::AX_X];
  assign result_o.thrust_y  = thr_q[cpid_pkg::AX_Y];
  assign result_o.thrust_z  = thr_q[cpid_pkg::AX_Z];
  assign result_o.yaw_drive = thr_q[cpid_pkg::AX_YAW];
  assign result_o.verr_x    = verr_q[cpid_pkg::AX_X];
  assign result_o.verr_y    = verr_q[cpid_pkg::AX_Y];
  assign result_o.verr_z    = verr_q[cpid_pkg::AX_Z];

endmodule

### rtl/core/cascaded_pid_thrust_yaw.sv
// Cascaded PID thrust and yaw controller in signed fixed point with FRAC_BITS
// fraction bits (Q16.16 by default). Each input word is one odometry sample and
// yields one output word with the three thrust commands, the yaw command and the
// three velocity errors. All arithmetic runs through one shared unit (a 32x32
// multiplier with a register behind it and one 64-bit adder with saturation)
// under a step sequencer, one step per cycle: 13 steps per axis in position
// mode, 11 in velocity mode and 10 for yaw; the sequencer then waits until the
// output register is free. The input side is ready again in the same cycle as
// the result appears in the output register, even while that result still
// waits to be taken. Configuration writes are always accepted and must only be
// issued while no sample is in work.
module cascaded_pid_thrust_yaw #(
  parameter int unsigned FRAC_BITS = cpid_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Fields from bit 0 up: pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, yaw_meas.
  input  logic [cpid_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // Fields from bit 0 up: thrust_x, thrust_y, thrust_z, yaw_drive,
  // verr_x, verr_y, verr_z.
  output logic [cpid_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [cpid_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [cpid_pkg::DATA_W-1:0]       cfg_data_i
);

  localparam int unsigned DW = cpid_pkg::DATA_W;
  localparam logic signed [cpid_pkg::WIDE_W-1:0] One = 64'sd1 <<< FRAC_BITS;

  cpid_pkg::cpid_cfg_t    cfg_q;
  cpid_pkg::cpid_sample_t sample;
  cpid_pkg::cpid_result_t result;
  logic                   seq_idle;
  logic                   seq_done;
  logic                   res_free;
  logic                   m_valid_q;
  logic [cpid_pkg::M_TDATA_W-1:0] m_data_q;

  // Unpack the input word.
  assign sample.pos_x    = s_axis_tdata[0*DW +: DW];
  assign sample.pos_y    = s_axis_tdata[1*DW +: DW];
  assign sample.pos_z    = s_axis_tdata[2*DW +: DW];
  assign sample.vel_x    = s_axis_tdata[3*DW +: DW];
  assign sample.vel_y    = s_axis_tdata[4*DW +: DW];
  assign sample.vel_z    = s_axis_tdata[5*DW +: DW];
  assign sample.yaw_meas = s_axis_tdata[6*DW +: cpid_pkg::YAW_W];

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.position_mode <= 1'b1;
      cfg_q.target_x      <= '0;
      cfg_q.target_y      <= '0;
      cfg_q.target_z      <= DW'(One * 2);
      cfg_q.yaw_target    <= '0;
      cfg_q.deriv_scale   <= cpid_pkg::SCALE_W'(One);
    end else if (cfg_valid_i) begin
      unique case (cpid_pkg::cfg_reg_e'(cfg_index_i))
        cpid_pkg::REG_POSITION_MODE: cfg_q.position_mode <= cfg_data_i[0];
        cpid_pkg::REG_TARGET_X:      cfg_q.target_x      <= cfg_data_i;
        cpid_pkg::REG_TARGET_Y:      cfg_q.target_y      <= cfg_data_i;
        cpid_pkg::REG_TARGET_Z:      cfg_q.target_z      <= cfg_data_i;
        cpid_pkg::REG_YAW_TARGET:
          cfg_q.yaw_target  <= cfg_data_i[cpid_pkg::YAW_W-1:0];
        cpid_pkg::REG_DERIV_SCALE:
          cfg_q.deriv_scale <= cfg_data_i[cpid_pkg::SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  cpid_seq #(
    .FRAC_BITS (FRAC_BITS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (s_axis_tvalid),
    .sample_i   (sample),
    .cfg_i      (cfg_q),
    .res_free_i (res_free),
    .idle_o     (seq_idle),
    .done_o     (seq_done),
    .result_o   (result)
  );

  assign s_axis_tready = seq_idle;

  // Output register; the sequencer only finishes when it is free.
  assign res_free = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (seq_done) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_done) begin
      m_data_q <= {result.verr_z, result.verr_y, result.verr_x, result.yaw_drive,
                   result.thrust_z, result.thrust_y, result.thrust_x};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

### rtl/core/cpid_chk.sv
module cpid_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic [cpid_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready
);

  // A sample in work blocks the input side.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted again right after a sample was taken");

  // A new result only appears after the sequencer has been busy.
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> ($past(!s_axis_tready) && $past(!s_axis_tready, 2)))
    else $error("result word appeared without a sample in work");

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result word changed or was dropped");

endmodule

bind cascaded_pid_thrust_yaw cpid_chk u_cpid_chk (.*);

### sim/tb_top.sv
module tb_top;
  import cpid_pkg::*;

  // Fixed-point constants of the controller, Q16.16 by default.
  localparam int     FRAC    = FRAC_BITS_DEF;
  localparam longint ONE_Q   = longint'(1) << FRAC;
  localparam longint HALF_Q  = ONE_Q / 2;
  localparam longint K_POS   = (ONE_Q + 2) / 5;
  localparam longint K_XY_P  = 4 * ONE_Q;
  localparam longint K_XY_D  = 2 * ONE_Q;
  localparam longint K_VEL_I = (ONE_Q + 12) / 25;
  localparam longint K_Z_P   = 10 * ONE_Q;
  localparam longint K_Z_D   = 7 * HALF_Q;
  localparam longint K_YAW_P = (3 * ONE_Q + 5) / 10;
  localparam longint K_YAW_D = HALF_Q;
  localparam longint HOVER   = 15 * ONE_Q;

  localparam logic [DATA_W-1:0] W_MAX      = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] W_MIN      = 32'h8000_0000;
  localparam int                YAW_LIMIT  = 205887;
  localparam logic [YAW_W-1:0]  YAW_PI     = 19'd205887;
  localparam logic [YAW_W-1:0]  YAW_NEG_PI = -19'sd205887;

  // Indexes beyond the register file; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 500;
  localparam int HOLD_AT_FIRST  = 150;
  localparam int HOLD_AT_SECOND = 660;
  localparam int END_WAIT       = 120;
  localparam int RANDOM_PHASES  = 11;
  localparam int PHASE_ITEMS    = 85;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [DATA_W-1:0]    cfg_data_i    = '0;

  // Odometry words waiting to be sent and command words still to arrive.
  logic [S_TDATA_W-1:0] odom_q [$];
  logic [M_TDATA_W-1:0] cmd_q [$];

  int odom_pushed  = 0;
  int outputs_seen = 0;
  int n_errors     = 0;
  int src_wait     = 0;
  int sink_wait    = 0;
  int hold_left    = 0;
  int idle_cycles  = 0;
  bit src_idle_en  = 1'b1;
  bit sink_idle_en = 1'b1;

  // Controller registers and loop state as the block should hold them.
  bit     ctl_pos_mode;
  longint ctl_target [NUM_VEL];
  longint ctl_yaw_target;
  longint ctl_dscale;
  longint err_last [NUM_AXES];
  longint err_prev [NUM_AXES];
  longint integ [NUM_AXES];

  string out_field [7] = '{"thrust_x", "thrust_y", "thrust_z", "yaw_drive",
                           "verr_x", "verr_y", "verr_z"};

  cascaded_pid_thrust_yaw u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic longint sat32(longint v);
    if (v > SAT_MAX) return SAT_MAX;
    if (v < SAT_MIN) return SAT_MIN;
    return v;
  endfunction

  // Exact product, plus one half, arithmetic shift: round half up.
  function automatic longint mul_rnd(longint a, longint b);
    return (a * b + HALF_Q) >>> FRAC;
  endfunction

  // Computes the command word for one odometry word and advances the loop state.
  function automatic logic [M_TDATA_W-1:0] control_step(logic [S_TDATA_W-1:0] odom);
    logic [M_TDATA_W-1:0]     cmd;
    logic signed [DATA_W-1:0] f32;
    logic signed [YAW_W-1:0]  f19;
    longint meas, vsp, err, num, drv, kp, kd, ki, bias, total;
    cmd = '0;
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      case (axis_e'(ax))
        AX_Z: begin
          kp = K_Z_P; kd = K_Z_D; ki = K_VEL_I; bias = HOVER;
        end
        AX_YAW: begin
          kp = K_YAW_P; kd = K_YAW_D; ki = 0; bias = 0;
        end
        default: begin
          kp = K_XY_P; kd = K_XY_D; ki = K_VEL_I; bias = 0;
        end
      endcase
      if (axis_e'(ax) == AX_YAW) begin
        // Yaw is taken as given, with no wrap to plus or minus pi.
        f19 = odom[2 * NUM_VEL * DATA_W +: YAW_W];
        meas = f19;
        err = sat32(ctl_yaw_target - meas);
      end else begin
        f32 = odom[ax * DATA_W +: DATA_W];
        meas = f32;
        vsp = ctl_target[ax];
        // In position mode the outer loop turns position error into a velocity target.
        if (ctl_pos_mode) vsp = sat32(mul_rnd(K_POS, sat32(ctl_target[ax] - meas)));
        f32 = odom[(ax + NUM_VEL) * DATA_W +: DATA_W];
        err = sat32(vsp - f32);
        cmd[(ax + NUM_AXES) * DATA_W +: DATA_W] = err[DATA_W-1:0];
      end
      // Three-point backward derivative, then the running integral.
      num = sat32(err_prev[ax] - 4 * err_last[ax] + 3 * err);
      drv = sat32(mul_rnd(num, ctl_dscale));
      err_prev[ax] = err_last[ax];
      err_last[ax] = err;
      integ[ax] = sat32(integ[ax] + mul_rnd(ki, err));
      total = sat32(mul_rnd(kp, err) + mul_rnd(kd, drv) + integ[ax] + bias);
      cmd[ax * DATA_W +: DATA_W] = total[DATA_W-1:0];
    end
    return cmd;
  endfunction

  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 19))
      0:       return W_MAX;
      1:       return W_MIN;
      2, 3, 4: return $urandom;
      5, 6, 7: return 32'($urandom_range(0, 1 << 24)) - 32'(1 << 23);
      default: return 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
    endcase
  endfunction

  // Mostly within plus or minus pi; now and then anything the field holds.
  function automatic logic [YAW_W-1:0] rand_yaw();
    if ($urandom_range(0, 4) == 0) return YAW_W'($urandom);
    return YAW_W'($urandom_range(0, 2 * YAW_LIMIT) - YAW_LIMIT);
  endfunction

  task automatic push_odom(input logic [DATA_W-1:0] px, input logic [DATA_W-1:0] py,
                           input logic [DATA_W-1:0] pz, input logic [DATA_W-1:0] vx,
                           input logic [DATA_W-1:0] vy, input logic [DATA_W-1:0] vz,
                           input logic [YAW_W-1:0] yaw);
    odom_q.push_back({{(S_TDATA_W - 6 * DATA_W - YAW_W){1'b0}},
                      yaw, vz, vy, vx, pz, py, px});
    odom_pushed++;
  endtask

  task automatic push_random(input int count);
    repeat (count) begin
      push_odom(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                rand_word(), rand_yaw());
    end
  endtask

  // Writes one register; the caller lowers valid after the last write of a batch.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    logic signed [DATA_W-1:0] s32;
    logic signed [YAW_W-1:0]  s19;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    s32 = val;
    s19 = val[YAW_W-1:0];
    case (idx)
      REG_POSITION_MODE: ctl_pos_mode = val[0];
      REG_TARGET_X, REG_TARGET_Y, REG_TARGET_Z: ctl_target[idx - REG_TARGET_X] = s32;
      REG_YAW_TARGET:    ctl_yaw_target = s19;
      REG_DERIV_SCALE:   ctl_dscale = longint'(val[SCALE_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic load_random_setting();
    logic [DATA_W-1:0] scale;
    case ($urandom_range(0, 5))
      0:       scale = '0;
      1:       scale = W_MAX;
      2:       scale = $urandom;
      default: scale = $urandom_range(1, 64) << FRAC;
    endcase
    write_reg(REG_POSITION_MODE, $urandom);
    write_reg(REG_TARGET_X, rand_word());
    write_reg(REG_TARGET_Y, rand_word());
    write_reg(REG_TARGET_Z, rand_word());
    if ($urandom_range(0, 3) == 0) write_reg(REG_YAW_TARGET, $urandom);
    else write_reg(REG_YAW_TARGET, 32'($urandom_range(0, 2 * YAW_LIMIT)) - YAW_LIMIT);
    write_reg(REG_DERIV_SCALE, scale);
    if ($urandom_range(0, 2) == 0) begin
      write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Returns once every command word owed so far has arrived.
  task automatic wait_drained();
    while (outputs_seen != odom_pushed) @(posedge clk_i);
  endtask

  // Sender: presents queued odometry words and predicts each accepted one.
  always @(posedge clk_i) begin
    logic offer;
    if (rst_ni) begin
      offer = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        cmd_q.push_back(control_step(s_axis_tdata));
        offer = 1'b0;
      end
      if (!offer) begin
        if (src_wait > 0) begin
          src_wait--;
        end else if (odom_q.size() != 0) begin
          s_axis_tdata <= odom_q.pop_front();
          offer = 1'b1;
          src_wait = src_idle_en ? $urandom_range(0, 16) : 0;
        end
      end
      s_axis_tvalid <= offer;
    end
  end

  // Receiver: checks each command word and stalls at random, twice for a long time.
  always @(posedge clk_i) begin
    logic [M_TDATA_W-1:0] want;
    logic                 rdy;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (cmd_q.size() == 0) begin
          $display("%0t: command word with none expected, got %h", $time, m_axis_tdata);
          n_errors++;
        end else begin
          want = cmd_q.pop_front();
          for (int f = 0; f < 7; f++) begin
            if (want[f * DATA_W +: DATA_W] !== m_axis_tdata[f * DATA_W +: DATA_W]) begin
              $display("%0t: %s expected %h, got %h", $time, out_field[f],
                       want[f * DATA_W +: DATA_W], m_axis_tdata[f * DATA_W +: DATA_W]);
              n_errors++;
            end
          end
          outputs_seen++;
          if (outputs_seen == HOLD_AT_FIRST || outputs_seen == HOLD_AT_SECOND) begin
            hold_left = LONG_HOLD;
          end
        end
        sink_wait = sink_idle_en ? $urandom_range(0, 16) : 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (sink_wait > 0) begin
        sink_wait--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      m_axis_tready <= rdy;
    end
  end

  // Watchdog: ends the run when no word moves on any channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[cascaded_pid_thrust_yaw] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    // Register values after reset.
    ctl_pos_mode   = 1'b1;
    ctl_target[0]  = 0;
    ctl_target[1]  = 0;
    ctl_target[2]  = 2 * ONE_Q;
    ctl_yaw_target = 0;
    ctl_dscale     = ONE_Q;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: field extremes, yaw beyond pi, full derivative swings.
    push_odom('0, '0, '0, '0, '0, '0, '0);
    push_odom(W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, YAW_PI);
    push_odom(W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, YAW_NEG_PI);
    push_odom(W_MIN, W_MIN, W_MIN, W_MAX, W_MAX, W_MAX, 19'h3FFFF);
    push_odom(W_MAX, W_MAX, W_MAX, W_MIN, W_MIN, W_MIN, 19'h40000);
    push_odom('1, '1, '1, '1, '1, '1, '1);
    push_odom(W_MIN, W_MIN, W_MIN, W_MAX, W_MAX, W_MAX, YAW_PI);
    push_odom(W_MAX, W_MAX, W_MAX, W_MIN, W_MIN, W_MIN, YAW_NEG_PI);
    push_odom(32'h0001_0000, 32'hFFFF_8000, 32'h0001_E666, 32'h0000_1000,
              32'hFFFF_F000, 32'h0000_0800, 19'h01000);
    push_odom(32'h0001_0400, 32'hFFFF_8400, 32'h0001_F000, 32'h0000_0C00,
              32'hFFFF_F400, 32'h0000_0400, 19'h00C00);
    push_odom(32'h0001_0800, 32'hFFFF_8800, 32'h0001_F800, 32'h0000_0800,
              32'hFFFF_F800, 32'h0000_0200, 19'h7F800);
    push_odom(32'h0001_0A00, 32'hFFFF_8A00, 32'h0002_0000, 32'h0000_0400,
              32'hFFFF_FC00, '0, 19'h7F000);
    push_odom(32'h0001_0B00, 32'hFFFF_8B00, 32'h0002_0100, '0, '0, 32'hFFFF_FF00, '0);
    wait_drained();

    // Velocity mode, x/y/z setpoints and the derivative scale at maximum, yaw at pi.
    write_reg(REG_POSITION_MODE, 32'hFFFF_FFFE);
    write_reg(REG_TARGET_X, W_MAX);
    write_reg(REG_TARGET_Y, W_MAX);
    write_reg(REG_TARGET_Z, W_MAX);
    write_reg(REG_YAW_TARGET, 32'(YAW_LIMIT));
    write_reg(REG_DERIV_SCALE, W_MAX);
    write_reg(REG_SPARE_LO, $urandom);
    cfg_valid_i <= 1'b0;
    push_random(6);
    wait_drained();

    // Position mode, x/y/z setpoints at minimum, yaw at minus pi; scale bit 31 dropped.
    write_reg(REG_POSITION_MODE, 32'h0000_0003);
    write_reg(REG_TARGET_X, W_MIN);
    write_reg(REG_TARGET_Y, W_MIN);
    write_reg(REG_TARGET_Z, W_MIN);
    write_reg(REG_YAW_TARGET, 32'h7FF0_0000 | 32'(YAW_NEG_PI));
    write_reg(REG_DERIV_SCALE, W_MIN);
    write_reg(REG_SPARE_HI, $urandom);
    cfg_valid_i <= 1'b0;
    push_random(6);
    wait_drained();

    // Random settings, each followed by a run of random samples.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      load_random_setting();
      src_idle_en  = ($urandom_range(0, 3) != 0);
      sink_idle_en = ($urandom_range(0, 3) != 0);
      push_random(PHASE_ITEMS);
      wait_drained();
    end

    repeat (END_WAIT) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("[cascaded_pid_thrust_yaw] OK");
    end else begin
      $display("[cascaded_pid_thrust_yaw] ERROR");
    end
    $finish;
  end

endmodule
